/* hw/rtl/qrd_pkg.sv */
// ----------------------------------------------------------------------------
// qrd_pkg
// Shared types, constants and helpers for the QR codeword de-interleaver.
// ----------------------------------------------------------------------------
package qrd_pkg;

    // Geometry limits
    localparam int MAX_BLOCKS    = 128;
    localparam int MAX_BLOCK_LEN = 256;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int BIDX_W  = 7;
    localparam int ROW_W   = 8;
    localparam int BLK_W   = 8;
    localparam int NBLK_W  = 9;   // holds the sum of both group counts
    localparam int LEN_W   = 10;  // data + EC + one
    localparam int CIDX_W  = 3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_SHORT_COUNT    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_SHORT_DATA_LEN = 8'd19;
    localparam logic [BYTE_W-1:0] RST_LONG_COUNT     = 8'd0;
    localparam logic [BYTE_W-1:0] RST_LONG_DATA_LEN  = 8'd0;
    localparam logic [BYTE_W-1:0] RST_EC_LEN         = 8'd7;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_SHORT_COUNT    = 3'd0,
        CFG_SHORT_DATA_LEN = 3'd1,
        CFG_LONG_COUNT     = 3'd2,
        CFG_LONG_DATA_LEN  = 3'd3,
        CFG_EC_LEN         = 3'd4
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_GEOM = 2'd1,
        ST_LEN  = 2'd2
    } t_status;

    // Position in the interleaved stream
    typedef enum logic [1:0] {
        PH_COMMON = 2'd0,
        PH_EXTRA  = 2'd1,
        PH_EC     = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [ROW_W-1:0]   row;
        logic [BLK_W-1:0]   block;
    } t_seq;

    // Block geometry derived from the registers
    typedef struct packed {
        logic               ok;
        logic [NBLK_W-1:0]  nblocks;
        logic [NBLK_W-1:0]  nshort;
        logic [BYTE_W-1:0]  dlen;
    } t_geom;

    // Move past phases that are already exhausted
    function automatic t_seq settle(t_seq s, t_geom g, logic [BYTE_W-1:0] ec_len);
        t_seq r;
        r = s;
        if (r.phase == PH_COMMON && r.row >= g.dlen) begin
            r.phase = PH_EXTRA;
            r.row   = '0;
            r.block = g.nshort[BLK_W-1:0];
        end
        if (r.phase == PH_EXTRA && {1'b0, r.block} >= g.nblocks) begin
            r.phase = PH_EC;
            r.row   = '0;
            r.block = '0;
        end
        if (r.phase == PH_EC && r.row >= ec_len) begin
            r.phase = PH_DONE;
            r.row   = '0;
            r.block = '0;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/qrd_if.sv */
// ----------------------------------------------------------------------------
// qrd interfaces
// Valid/ready channels for raw codewords, placed codewords and register writes.
// ----------------------------------------------------------------------------

// Raw codeword channel
interface qrd_in_if;
    import qrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] raw_byte;
    logic              last_byte;

    modport source (output valid, raw_byte, last_byte, input ready);
    modport sink   (input valid, raw_byte, last_byte, output ready);
endinterface

// Placed codeword channel
interface qrd_out_if;
    import qrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BIDX_W-1:0] block_index;
    logic [ROW_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic              is_data;
    logic [1:0]        status;
    logic              end_of_stream;

    modport source (output valid, block_index, position, value, is_data, status,
                    end_of_stream, input ready);
    modport sink   (input valid, block_index, position, value, is_data, status,
                    end_of_stream, output ready);
endinterface

// Register write channel
interface qrd_cfg_if;
    import qrd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [BYTE_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/qr_codeword_deinterleave.sv */
// ----------------------------------------------------------------------------
// qr_codeword_deinterleave
// Places each raw QR codeword into its block, position and data/EC class.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one raw codeword per word, last_byte marking the final one.
//   o_out  returns one word per raw codeword: block index, position, the byte,
//          data/EC flag, status and end-of-stream.
//   i_cfg  writes the five geometry registers; it is always ready and is
//          meant to be used only while no codeword is in flight.
// Timing:
//   A word accepted on i_in passes the input register, then the result register,
//   before it appears on o_out. One word per cycle is sustained while o_out is
//   ready; the only loop is the row/block/phase counter update.
// Reset:
//   i_rst_n (synchronous, low) loads the register defaults, empties both
//   stages and returns the sequence to the first data row.
// Stall:
//   While o_out is held the result stays put; the input register still takes
//   one more word, after which i_in.ready drops until o_out drains.
//   A word marked last_byte returns the sequence to its start.
// ----------------------------------------------------------------------------
module qr_codeword_deinterleave (
    input  logic  i_clk,
    input  logic  i_rst_n,
    qrd_in_if.sink    i_in,
    qrd_out_if.source o_out,
    qrd_cfg_if.sink   i_cfg
);
    import qrd_pkg::*;

    // Geometry registers
    logic [BYTE_W-1:0] r_short_count, r_short_data_len, r_long_count;
    logic [BYTE_W-1:0] r_long_data_len, r_ec_len;

    // Input stage
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;

    // Sequence state
    t_seq r_seq, n_seq;
    logic r_overrun, n_overrun;

    // Result stage
    logic              r_out_valid;
    logic [BIDX_W-1:0] r_out_bidx, n_out_bidx;
    logic [ROW_W-1:0]  r_out_pos, n_out_pos;
    logic [BYTE_W-1:0] r_out_value;
    logic              r_out_isd, n_out_isd;
    t_status           r_out_status, n_out_status;
    logic              r_out_eos;

    logic  advance, s1_fire, in_fire;
    t_geom geom;
    logic  has_long;
    logic [LEN_W-1:0] blk_len;
    t_seq  seq_a, seq_b, seq_c;
    logic  ovr_step;
    logic [BYTE_W:0] blk_inc;

    // Handshakes
    assign advance     = !r_out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && advance;
    assign i_in.ready  = !r_s1_valid || advance;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_count    <= RST_SHORT_COUNT;
            r_short_data_len <= RST_SHORT_DATA_LEN;
            r_long_count     <= RST_LONG_COUNT;
            r_long_data_len  <= RST_LONG_DATA_LEN;
            r_ec_len         <= RST_EC_LEN;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_SHORT_COUNT:    r_short_count    <= i_cfg.data;
                CFG_SHORT_DATA_LEN: r_short_data_len <= i_cfg.data;
                CFG_LONG_COUNT:     r_long_count     <= i_cfg.data;
                CFG_LONG_DATA_LEN:  r_long_data_len  <= i_cfg.data;
                CFG_EC_LEN:         r_ec_len         <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Block geometry
    always_comb begin
        geom.ok      = 1'b1;
        geom.nblocks = {1'b0, r_short_count} + {1'b0, r_long_count};
        has_long     = 1'b0;
        if (r_short_count == '0) begin
            geom.nshort = {1'b0, r_long_count};
            geom.dlen   = r_long_data_len;
        end else begin
            geom.nshort = {1'b0, r_short_count};
            geom.dlen   = r_short_data_len;
            if (r_long_count != '0) begin
                if (r_long_data_len == r_short_data_len) begin
                    geom.nshort = geom.nblocks;
                end else if ({1'b0, r_long_data_len} == {1'b0, r_short_data_len} + 9'd1) begin
                    has_long = 1'b1;
                end else begin
                    geom.ok = 1'b0;
                end
            end
        end
        if (geom.nblocks == '0 || geom.nblocks > NBLK_W'(MAX_BLOCKS))
            geom.ok = 1'b0;
        blk_len = LEN_W'(geom.dlen) + LEN_W'(r_ec_len) + LEN_W'(has_long);
        if (blk_len > LEN_W'(MAX_BLOCK_LEN))
            geom.ok = 1'b0;
    end

    // Placement of the word in the input stage
    always_comb begin
        seq_a        = settle(r_seq, geom, r_ec_len);
        seq_b        = seq_a;
        ovr_step     = r_overrun;
        n_out_bidx   = '0;
        n_out_pos    = '0;
        n_out_isd    = 1'b0;
        n_out_status = ST_OK;
        blk_inc      = {1'b0, seq_a.block} + 9'd1;
        case (seq_a.phase)
            PH_COMMON: begin
                n_out_bidx = seq_a.block[BIDX_W-1:0];
                n_out_pos  = seq_a.row;
                n_out_isd  = 1'b1;
                if (blk_inc >= geom.nblocks) begin
                    seq_b.block = '0;
                    seq_b.row   = seq_a.row + 8'd1;
                end else begin
                    seq_b.block = blk_inc[BLK_W-1:0];
                end
            end
            PH_EXTRA: begin
                n_out_bidx  = seq_a.block[BIDX_W-1:0];
                n_out_pos   = geom.dlen;
                n_out_isd   = 1'b1;
                seq_b.block = blk_inc[BLK_W-1:0];
            end
            PH_EC: begin
                n_out_bidx = seq_a.block[BIDX_W-1:0];
                n_out_pos  = geom.dlen + seq_a.row
                           + ROW_W'({1'b0, seq_a.block} >= geom.nshort);
                if (blk_inc >= geom.nblocks) begin
                    seq_b.block = '0;
                    seq_b.row   = seq_a.row + 8'd1;
                end else begin
                    seq_b.block = blk_inc[BLK_W-1:0];
                end
            end
            default: begin
                ovr_step     = 1'b1;
                n_out_status = ST_LEN;
            end
        endcase
        seq_c = settle(seq_b, geom, r_ec_len);
        if (r_s1_last && (ovr_step || seq_c.phase != PH_DONE))
            n_out_status = ST_LEN;

        // Inconsistent geometry: nothing placed, sequence holds unless the word is last
        n_seq     = seq_c;
        n_overrun = ovr_step;
        if (!geom.ok) begin
            n_out_bidx   = '0;
            n_out_pos    = '0;
            n_out_isd    = 1'b0;
            n_out_status = ST_GEOM;
            n_seq        = r_seq;
            n_overrun    = r_overrun;
        end
        if (r_s1_last) begin
            n_seq     = '{phase: PH_COMMON, row: '0, block: '0};
            n_overrun = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seq       <= '{phase: PH_COMMON, row: '0, block: '0};
            r_overrun   <= 1'b0;
        end else begin
            if (i_in.ready)
                r_s1_valid <= i_in.valid;
            if (advance)
                r_out_valid <= r_s1_valid;
            if (s1_fire) begin
                r_seq     <= n_seq;
                r_overrun <= n_overrun;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in.raw_byte;
            r_s1_last <= i_in.last_byte;
        end
        if (s1_fire) begin
            r_out_bidx   <= n_out_bidx;
            r_out_pos    <= n_out_pos;
            r_out_value  <= r_s1_byte;
            r_out_isd    <= n_out_isd;
            r_out_status <= n_out_status;
            r_out_eos    <= r_s1_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.block_index   = r_out_bidx;
    assign o_out.position      = r_out_pos;
    assign o_out.value         = r_out_value;
    assign o_out.is_data       = r_out_isd;
    assign o_out.status        = r_out_status;
    assign o_out.end_of_stream = r_out_eos;

endmodule

/* hw/rtl/qrd_checker.sv */
// ----------------------------------------------------------------------------
// qrd_checker
// Port-level checks for the de-interleaver, bound to the top level.
// ----------------------------------------------------------------------------
module qrd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [qrd_pkg::BIDX_W-1:0] i_block_index,
    input logic [qrd_pkg::ROW_W-1:0]  i_position,
    input logic [qrd_pkg::BYTE_W-1:0] i_value,
    input logic                      i_is_data,
    input logic [1:0]                i_status,
    input logic                      i_end_of_stream
);
    import qrd_pkg::*;

    // A held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_block_index, i_position, i_value, i_is_data, i_status,
                        i_end_of_stream}))
        else $error("result word changed while stalled");

    // Bad geometry places nothing
    a_geom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_GEOM |->
            i_block_index == '0 && i_position == '0 && !i_is_data)
        else $error("placement reported with inconsistent geometry");

    // An extra byte mid-stream places nothing
    a_extra_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_LEN && !i_end_of_stream |->
            i_block_index == '0 && i_position == '0 && !i_is_data)
        else $error("placement reported for an extra byte");

endmodule

bind qr_codeword_deinterleave qrd_checker u_qrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_block_index   (o_out.block_index),
    .i_position      (o_out.position),
    .i_value         (o_out.value),
    .i_is_data       (o_out.is_data),
    .i_status        (o_out.status),
    .i_end_of_stream (o_out.end_of_stream)
);

/* test/qr_codeword_deinterleave_test.sv */
// ----------------------------------------------------------------------------
// qr_codeword_deinterleave_test
// Self-checking bench for the QR codeword de-interleaver. A placement
// predictor tracks the phase/row/block walk of the raw stream and queues the
// expected block, position and status of every accepted codeword; results are
// compared word by word. Geometries cover small mixed groups, the count and
// length extremes and inconsistent settings, with full, short, overlong and
// unterminated streams, random gaps on both channels and register writes
// only while the block is drained.
// ----------------------------------------------------------------------------
package qrd_test_pkg;
    import qrd_pkg::*;

    // One placed codeword as seen on the result channel
    typedef struct packed {
        logic [BIDX_W-1:0] block_index;
        logic [ROW_W-1:0]  position;
        logic [BYTE_W-1:0] value;
        logic              is_data;
        t_status           status;
        logic              eos;
    } t_place;

    // Register set, indexed by t_cfg_idx
    typedef logic [4:0][BYTE_W-1:0] t_geo_regs;

    class placement_board;
        int     errors;
        t_place expected_places[$];

        // register copies
        int reg_short_count;
        int reg_short_len;
        int reg_long_count;
        int reg_long_len;
        int reg_ec_len;

        // walk through the interleaved stream
        t_phase walk_phase;
        int     walk_row;
        int     walk_blk;
        bit     overran;

        function new();
            errors          = 0;
            reg_short_count = RST_SHORT_COUNT;
            reg_short_len   = RST_SHORT_DATA_LEN;
            reg_long_count  = RST_LONG_COUNT;
            reg_long_len    = RST_LONG_DATA_LEN;
            reg_ec_len      = RST_EC_LEN;
            restart_walk();
        endfunction

        function void restart_walk();
            walk_phase = PH_COMMON;
            walk_row   = 0;
            walk_blk   = 0;
            overran    = 1'b0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [BYTE_W-1:0] d);
            case (idx)
                CFG_SHORT_COUNT:    reg_short_count = d;
                CFG_SHORT_DATA_LEN: reg_short_len   = d;
                CFG_LONG_COUNT:     reg_long_count  = d;
                CFG_LONG_DATA_LEN:  reg_long_len    = d;
                CFG_EC_LEN:         reg_ec_len      = d;
                default: ;  // spare indexes hold nothing
            endcase
        endfunction

        // Block groups from the registers; nsh blocks are the shorter ones
        function void derive_groups(output bit ok, output int nblk, output int nsh,
                                    output int dl);
            bit longer;
            ok     = 1'b1;
            longer = 1'b0;
            nblk   = reg_short_count + reg_long_count;
            if (reg_short_count == 0) begin
                nsh = reg_long_count;
                dl  = reg_long_len;
            end else begin
                nsh = reg_short_count;
                dl  = reg_short_len;
                if (reg_long_count != 0) begin
                    if (reg_long_len == reg_short_len)
                        nsh = nblk;
                    else if (reg_long_len == reg_short_len + 1)
                        longer = 1'b1;
                    else
                        ok = 1'b0;
                end
            end
            if (nblk == 0 || nblk > MAX_BLOCKS)
                ok = 1'b0;
            if (dl + reg_ec_len + int'(longer) > MAX_BLOCK_LEN)
                ok = 1'b0;
        endfunction

        // Bytes in a complete stream, or -1 when the groups are inconsistent
        function int stream_len();
            bit ok;
            int nblk, nsh, dl;
            derive_groups(ok, nblk, nsh, dl);
            if (!ok)
                return -1;
            return nblk * (dl + reg_ec_len) + nblk - nsh;
        endfunction

        // Step over phases that have nothing left
        function void skip_spent(int nblk, int nsh, int dl);
            if (walk_phase == PH_COMMON && walk_row >= dl) begin
                walk_phase = PH_EXTRA;
                walk_row   = 0;
                walk_blk   = nsh;
            end
            if (walk_phase == PH_EXTRA && walk_blk >= nblk) begin
                walk_phase = PH_EC;
                walk_row   = 0;
                walk_blk   = 0;
            end
            if (walk_phase == PH_EC && walk_row >= reg_ec_len) begin
                walk_phase = PH_DONE;
                walk_row   = 0;
                walk_blk   = 0;
            end
        endfunction

        function void next_slot(int nblk);
            walk_blk++;
            if (walk_blk >= nblk) begin
                walk_blk = 0;
                walk_row++;
            end
        endfunction

        // Work out where an accepted raw codeword goes and queue it
        function void note_input(logic [BYTE_W-1:0] b, logic l);
            t_place e;
            bit     ok;
            int     nblk, nsh, dl, bidx, pos;
            derive_groups(ok, nblk, nsh, dl);
            bidx      = 0;
            pos       = 0;
            e.is_data = 1'b0;
            e.value   = b;
            e.eos     = l;
            e.status  = ST_OK;
            if (!ok) begin
                e.status = ST_GEOM;
            end else begin
                skip_spent(nblk, nsh, dl);
                case (walk_phase)
                    PH_COMMON: begin
                        bidx      = walk_blk;
                        pos       = walk_row;
                        e.is_data = 1'b1;
                        next_slot(nblk);
                    end
                    PH_EXTRA: begin
                        bidx      = walk_blk;
                        pos       = dl;
                        e.is_data = 1'b1;
                        walk_blk++;
                    end
                    PH_EC: begin
                        // longer blocks keep their EC one further on
                        bidx = walk_blk;
                        pos  = dl + walk_row + int'(walk_blk >= nsh);
                        next_slot(nblk);
                    end
                    default: begin
                        overran  = 1'b1;
                        e.status = ST_LEN;
                    end
                endcase
                skip_spent(nblk, nsh, dl);
                if (l && (overran || walk_phase != PH_DONE))
                    e.status = ST_LEN;
            end
            e.block_index = bidx[BIDX_W-1:0];
            e.position    = pos[ROW_W-1:0];
            expected_places.push_back(e);
            if (l)
                restart_walk();
        endfunction

        function int pending();
            return expected_places.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(t_place got);
            t_place e;
            if (expected_places.size() == 0) begin
                report($sformatf("unexpected word: block %0d pos %0d value %0h",
                                 got.block_index, got.position, got.value));
                return;
            end
            e = expected_places.pop_front();
            if (got.block_index !== e.block_index)
                report($sformatf("block_index %0d, expected %0d",
                                 got.block_index, e.block_index));
            if (got.position !== e.position)
                report($sformatf("position %0d, expected %0d", got.position, e.position));
            if (got.value !== e.value)
                report($sformatf("value %0h, expected %0h", got.value, e.value));
            if (got.is_data !== e.is_data)
                report($sformatf("is_data %0b, expected %0b", got.is_data, e.is_data));
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.eos !== e.eos)
                report($sformatf("end_of_stream %0b, expected %0b", got.eos, e.eos));
        endtask
    endclass

endpackage

module qr_codeword_deinterleave_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qrd_pkg::*;
    import qrd_test_pkg::*;

    localparam int                WATCHDOG_LIMIT = 1000;
    localparam int                ITEM_TARGET    = 800;
    localparam int                DIRECTED_LEN   = 26;  // one full stream at reset geometry
    localparam int                N_EDGE         = 14;
    localparam logic [CIDX_W-1:0] CFG_SPARE      = 3'd7;

    logic i_clk;
    logic i_rst_n;

    qrd_in_if  in_if ();
    qrd_out_if out_if ();
    qrd_cfg_if cfg_if ();

    qr_codeword_deinterleave u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    placement_board board;

    bit tx_up;
    bit tx_calm;
    bit rx_calm;
    int items_sent;
    int idle_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_geo_regs geo(int sc, int sdl, int lc, int ldl, int ec);
        t_geo_regs g;
        g[CFG_SHORT_COUNT]    = sc[7:0];
        g[CFG_SHORT_DATA_LEN] = sdl[7:0];
        g[CFG_LONG_COUNT]     = lc[7:0];
        g[CFG_LONG_DATA_LEN]  = ldl[7:0];
        g[CFG_EC_LEN]         = ec[7:0];
        return g;
    endfunction

    // Register extremes and inconsistent groups
    function automatic t_geo_regs edge_geometry(int k);
        case (k)
            0:       return geo(128, 0, 0, 0, 1);      // most blocks, EC only
            1:       return geo(0, 1, 6, 1, 0);        // second group stands alone
            2:       return geo(1, 255, 0, 0, 1);      // longest data, full block
            3:       return geo(1, 0, 0, 0, 255);      // longest EC
            4:       return geo(2, 3, 3, 4, 2);        // longer blocks, shifted EC
            5:       return geo(3, 2, 2, 2, 1);        // equal lengths, one group
            6:       return geo(1, 4, 1, 5, 252);      // one over with the extra byte
            7:       return geo(0, 5, 0, 5, 3);        // no blocks
            8:       return geo(100, 1, 29, 1, 1);     // one block too many
            9:       return geo(2, 4, 1, 3, 2);        // long group shorter
            10:      return geo(1, 250, 0, 0, 7);      // block too long
            11:      return geo(255, 255, 255, 255, 255);
            12:      return geo(0, 0, 0, 0, 0);
            default: return geo(1, 0, 0, 0, 0);        // empty stream, all overrun
        endcase
    endfunction

    function automatic t_geo_regs random_geometry();
        int r, sc, sdl, lc, ldl, ec;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            if (r < 65) begin
                sc  = $urandom_range(0, 4);
                lc  = $urandom_range(0, 4);
                sdl = $urandom_range(0, 8);
                ec  = $urandom_range(0, 8);
            end else begin
                sc  = $urandom_range(0, 24);
                lc  = $urandom_range(0, 8);
                sdl = $urandom_range(0, 2);
                ec  = $urandom_range(0, 2);
            end
            if (sc + lc == 0)
                lc = 1;
            if (sc == 0)
                ldl = $urandom_range(0, 8);
            else
                ldl = sdl + $urandom_range(0, 1);
            return geo(sc, sdl, lc, ldl, ec);
        end
        return geo($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // Send one raw codeword; valid stays high into the next word when no gap
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic l);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            if (tx_up)
                in_if.valid <= 1'b0;
            tx_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.raw_byte  <= b;
        in_if.last_byte <= l;
        tx_up = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // Hold the sender until every expected word has come back
    task automatic wait_drain();
        if (tx_up)
            in_if.valid <= 1'b0;
        tx_up = 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic drive_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Last write settles in the predictor before the stream is planned
    task automatic load_geometry(input t_geo_regs g);
        drive_reg(CFG_SHORT_COUNT, g[CFG_SHORT_COUNT]);
        drive_reg(CFG_SHORT_DATA_LEN, g[CFG_SHORT_DATA_LEN]);
        drive_reg(CFG_LONG_COUNT, g[CFG_LONG_COUNT]);
        drive_reg(CFG_LONG_DATA_LEN, g[CFG_LONG_DATA_LEN]);
        drive_reg(CFG_EC_LEN, g[CFG_EC_LEN]);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A few streams under the current geometry; for a consistent one of modest size
    // mostly complete, some cut short, some overlong, and now and then one left open
    task automatic run_phase();
        int total, n, len, k;
        bit close;
        total = board.stream_len();
        if (total < 0)
            n = $urandom_range(1, 3);
        else if (total > 40)
            n = 1;
        else
            n = $urandom_range(1, 2);
        for (int s = 0; s < n; s++) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            close   = 1'b1;
            k       = $urandom_range(0, 99);
            if (total < 0)
                len = $urandom_range(1, 6);
            else if (total > 300)
                len = $urandom_range(1, 40);  // keep chance huge geometries brief
            else if ((total > 40 && s == 0) || k < 65)
                len = (total == 0) ? 1 : total;
            else if (k < 78)
                len = (total > 1) ? $urandom_range(1, total - 1) : 1;
            else if (k < 92)
                len = total + $urandom_range(1, 3);
            else begin
                len   = $urandom_range(1, (total > 0) ? total : 1);
                close = 1'b0;
            end
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
            if ($urandom_range(0, 7) == 0)
                wait_drain();
        end
    endtask

    // Result side: random stalls, some stretches always ready
    initial begin : rx_side
        int hold;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
                hold = pick_gap(rx_calm);
            end
        end
    end

    // Monitors and watchdog
    always @(posedge i_clk) begin : watch
        t_place got;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                board.set_reg(cfg_if.index, cfg_if.data);
                moved = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                board.note_input(in_if.raw_byte, in_if.last_byte);
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                got.block_index = out_if.block_index;
                got.position    = out_if.position;
                got.value       = out_if.value;
                got.is_data     = out_if.is_data;
                got.status      = t_status'(out_if.status);
                got.eos         = out_if.end_of_stream;
                board.check(got);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        t_geo_regs   g;
        logic [7:0]  b;
        int          phase_no;
        int          edge_no;
        board       = new();
        tx_up       = 1'b0;
        tx_calm     = 1'b1;
        rx_calm     = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        phase_no    = 0;
        edge_no     = 0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.raw_byte  <= '0;
        in_if.last_byte <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one complete stream at reset geometry, byte extremes up front
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            case (i)
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'hAA;
                3:       b = 8'h55;
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_byte(b, i == DIRECTED_LEN - 1);
        end

        // geometry phases, extremes spread among random ones
        while (items_sent < DIRECTED_LEN + ITEM_TARGET || edge_no < N_EDGE) begin
            if (phase_no % 3 != 0 && edge_no < N_EDGE) begin
                g = edge_geometry(edge_no);
                edge_no++;
            end else begin
                g = random_geometry();
            end
            wait_drain();
            if (phase_no == 0)
                drive_reg(CFG_SPARE, 8'hA5);  // index with no register behind it
            load_geometry(g);
            rx_calm = ($urandom_range(0, 4) == 0);
            run_phase();
            phase_no++;
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (board.pending() != 0)
            board.report($sformatf("%0d words never arrived", board.pending()));
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
